// ----- hdl/ttli_pkg.sv -----
// Shared types and constants for the time-table linear interpolator.
`timescale 1ns / 1ps
`default_nettype none
package ttli_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int NUM_CH      = 6;
    localparam int FM_W        = 49;   // |factor| < 2^49
    localparam int DIVR_W      = 33;   // |time gap| <= 2^32
    localparam int ADDR_W      = 4;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_MARK     = 2'd0,
        REG_CENTRE_X = 2'd1,
        REG_CENTRE_Y = 2'd2,
        REG_CENTRE_Z = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_WALK_CMP,
        ST_PREV,
        ST_DIV,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_FIN,
        ST_EMIT
    } state_t;

    // One table entry: time stamp then lin xyz, ang xyz
    typedef struct packed {
        logic [31:0]              tstamp;
        logic [NUM_CH-1:0][31:0]  ch;
    } entry_t;

endpackage
`default_nettype wire

// ----- hdl/ttli_mem.sv -----
// Table storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ttli_mem
    import ttli_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire entry_t           wdata,
    input  wire logic             re,
    input  wire logic [IDX_W-1:0] raddr,
    output entry_t                rdata
);

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ttli_div.sv -----
// Restoring divider, one quotient bit per cycle, for the Q33.16 factor.
`timescale 1ns / 1ps
`default_nettype none
module ttli_div
    import ttli_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [FM_W-1:0]   dividend,
    input  wire logic [DIVR_W-1:0] divisor,
    output logic                   done,
    output logic [FM_W-1:0]        quotient
);

    localparam int CNT_DW = $clog2(FM_W + 1);

    logic [DIVR_W:0]     rem_reg, rem_next;
    logic [FM_W-1:0]     dvd_reg, dvd_next;
    logic [DIVR_W-1:0]   dvs_reg;
    logic [CNT_DW-1:0]   cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DIVR_W:0]     trial;
    logic                ge;

    always_comb begin
        trial    = {rem_reg[DIVR_W-1:0], dvd_reg[FM_W-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? (trial - {1'b0, dvs_reg}) : trial;
        dvd_next = {dvd_reg[FM_W-2:0], ge};
        cnt_next = cnt_reg - CNT_DW'(1);
        done_next = (cnt_reg == CNT_DW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_DW'(FM_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

// ----- hdl/time_table_linear_interpolator_unit.sv -----
// Top level: time-table linear interpolator with APB register port.
`timescale 1ns / 1ps
`default_nettype none
// Piecewise linear lookup over a table of time-stamped six-channel vectors.
// Input channel s_*: valid/ready, one item per handshake. s_func selects
//   clear (table empty, cursor 0), append (stored at entry_count, dropped
//   when full) or query (one result item on m_*). Code 3 is ignored.
// Clear and append complete when accepted. A query steps the cursor with a
//   read state and a compare state (read-compare loop on the single table read
//   port), then reads the previous entry, runs the bit-serial factor divider
//   (skipped for a zero time gap), runs a high-product, low-product and finish
//   state per channel on the shared 33x33 multiplier, and loads the output
//   register. Queries on a table with fewer than two entries, or before the
//   first entry's time while the cursor is still at entry 0, skip the
//   interpolation and go straight to the output register.
// One item is processed at a time; s_ready is high only while idle.
// The result sits in an output register; a stalled receiver holds it and
//   the next item may be accepted, but its result waits for the register.
// APB writes set mark_value and centre_x/y/z (byte addresses 0,4,8,12);
//   reads return them. Write them only while the block is idle.
// Reset (aresetn low, synchronous) empties the table, zeroes the cursor and
//   the registers and drops any pending result. Table contents are not
//   cleared; only entries below the fill count are ever read.
module time_table_linear_interpolator_unit
    import ttli_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // input items
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_func,
    input  wire logic signed [31:0] s_time_value,
    input  wire logic signed [31:0] s_lin_x,
    input  wire logic signed [31:0] s_lin_y,
    input  wire logic signed [31:0] s_lin_z,
    input  wire logic signed [31:0] s_ang_x,
    input  wire logic signed [31:0] s_ang_y,
    input  wire logic signed [31:0] s_ang_z,
    // result items
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_status,
    output logic signed [31:0]     m_acc_lin_x,
    output logic signed [31:0]     m_acc_lin_y,
    output logic signed [31:0]     m_acc_lin_z,
    output logic signed [31:0]     m_acc_ang_x,
    output logic signed [31:0]     m_acc_ang_y,
    output logic signed [31:0]     m_acc_ang_z,
    output logic [15:0]            m_mark_out,
    output logic signed [31:0]     m_cog_out_x,
    output logic signed [31:0]     m_cog_out_y,
    output logic signed [31:0]     m_cog_out_z
);

    localparam int CH_W = $clog2(NUM_CH);

    // ---------------- configuration registers ----------------
    logic [15:0] mark_reg;
    logic [31:0] cx_reg, cy_reg, cz_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_MARK:     mark_reg <= pwdata[15:0];
                REG_CENTRE_X: cx_reg   <= pwdata;
                REG_CENTRE_Y: cy_reg   <= pwdata;
                REG_CENTRE_Z: cz_reg   <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_MARK:     prdata = {16'b0, mark_reg};
            REG_CENTRE_X: prdata = cx_reg;
            REG_CENTRE_Y: prdata = cy_reg;
            REG_CENTRE_Z: prdata = cz_reg;
            default:      prdata = '0;
        endcase
    end

    // ---------------- control state ----------------
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  cursor_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              m_valid_reg;

    // ---------------- datapath registers ----------------
    logic signed [31:0]  t_reg;
    entry_t              cur_reg, prev_reg;
    logic [FM_W-1:0]     fm_reg;
    logic                negf_reg;
    logic [49:0]         phi_reg;
    logic [65:0]         plo_reg;
    logic [NUM_CH-1:0][31:0] acc_reg;
    logic                status_reg;
    logic [NUM_CH-1:0][31:0] out_acc_reg;
    logic                out_status_reg;
    logic [15:0]         out_mark_reg;
    logic [31:0]         out_cx_reg, out_cy_reg, out_cz_reg;

    // ---------------- table memory ----------------
    entry_t            mem_rdata, mem_wdata;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_raddr;

    logic accept, is_last, walk_adv, emit_go, cur_is_first, table_full;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid & s_ready;
    assign table_full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign is_last      = ({1'b0, cursor_reg} == (count_reg - CNT_W'(1)));
    assign walk_adv     = !is_last && ($signed(t_reg) >= $signed(mem_rdata.tstamp));
    assign cur_is_first = (cursor_reg == '0);
    assign emit_go      = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign mem_wdata.tstamp = s_time_value;
    assign mem_wdata.ch     = {s_ang_z, s_ang_y, s_ang_x, s_lin_z, s_lin_y, s_lin_x};

    ttli_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- factor terms ----------------
    logic signed [32:0] off_s, gap_s;
    logic [32:0]        off_m, gap_m;
    logic               div_start, div_done;
    logic [FM_W-1:0]    div_q;

    assign off_s = {t_reg[31], t_reg} - {mem_rdata.tstamp[31], mem_rdata.tstamp};
    assign gap_s = {cur_reg.tstamp[31], cur_reg.tstamp}
                 - {mem_rdata.tstamp[31], mem_rdata.tstamp};
    assign off_m = off_s[32] ? (33'd0 - off_s) : off_s;
    assign gap_m = gap_s[32] ? (33'd0 - gap_s) : gap_s;
    assign div_start = (state_reg == ST_PREV) && (gap_s != '0);

    ttli_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({off_m[32:0], 16'b0}),
        .divisor  (gap_m),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- per-channel interpolation ----------------
    logic signed [31:0] pv, cv;
    logic signed [32:0] d_s;
    logic [32:0]        dm;
    logic [32:0]        mul_a;
    logic [65:0]        prod;
    logic [50:0]        mag;
    logic               sat, neg;
    logic signed [35:0] r_s;
    logic [31:0]        lerp_val;

    always_comb begin
        pv    = prev_reg.ch[ch_reg];
        cv    = cur_reg.ch[ch_reg];
        d_s   = {cv[31], cv} - {pv[31], pv};
        dm    = d_s[32] ? (33'd0 - d_s) : d_s;
        mul_a = (state_reg == ST_MUL_HI) ? {16'b0, fm_reg[FM_W-1:32]}
                                         : {1'b0, fm_reg[31:0]};
        prod  = mul_a * dm;
        // high partial product alone already past the range
        mag   = {17'b0, phi_reg[17:0], 16'b0} + {1'b0, plo_reg[65:16]};
        sat   = (phi_reg >= 50'(1 << 18)) || (mag >= 51'(64'd1 << 34));
        neg   = negf_reg ^ d_s[32];
        r_s   = neg ? ({{4{pv[31]}}, pv} - {2'b0, mag[33:0]})
                    : ({{4{pv[31]}}, pv} + {2'b0, mag[33:0]});
        if (sat) begin
            lerp_val = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else if (r_s > 36'sd2147483647) begin
            lerp_val = 32'h7fff_ffff;
        end else if (r_s < -36'sd2147483648) begin
            lerp_val = 32'h8000_0000;
        end else begin
            lerp_val = r_s[31:0];
        end
    end

    // ---------------- state machine ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (func_t'(s_func) == FUNC_QUERY)) begin
                    state_next = (count_reg < CNT_W'(2)) ? ST_EMIT : ST_WALK;
                end
            end
            ST_WALK:     state_next = ST_WALK_CMP;
            ST_WALK_CMP: begin
                if (walk_adv) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = cur_is_first ? ST_EMIT : ST_PREV;
                end
            end
            ST_PREV:   state_next = (gap_s == '0) ? ST_MUL_HI : ST_DIV;
            ST_DIV:    state_next = div_done ? ST_MUL_HI : ST_DIV;
            ST_MUL_HI: state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_FIN;
            ST_FIN:    state_next = (ch_reg == CH_W'(NUM_CH - 1)) ? ST_EMIT : ST_MUL_HI;
            ST_EMIT:   state_next = emit_go ? ST_IDLE : ST_EMIT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = cursor_reg;
        unique case (state_reg)
            ST_IDLE: begin
                mem_we = accept && (func_t'(s_func) == FUNC_APPEND) && !table_full;
            end
            ST_WALK: mem_re = 1'b1;
            ST_WALK_CMP: begin
                mem_re    = !walk_adv && !cur_is_first;
                mem_raddr = cursor_reg - IDX_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            ch_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (func_t'(s_func))
                            FUNC_CLEAR: begin
                                count_reg  <= '0;
                                cursor_reg <= '0;
                            end
                            FUNC_APPEND: begin
                                if (!table_full) count_reg <= count_reg + CNT_W'(1);
                            end
                            FUNC_QUERY: begin
                                if (count_reg >= CNT_W'(2)
                                    && {1'b0, cursor_reg} >= count_reg) begin
                                    cursor_reg <= IDX_W'(count_reg - CNT_W'(1));
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WALK_CMP: begin
                    if (walk_adv) cursor_reg <= cursor_reg + IDX_W'(1);
                    ch_reg <= '0;
                end
                ST_FIN: ch_reg <= ch_reg + CH_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                t_reg      <= s_time_value;
                status_reg <= (count_reg < CNT_W'(2));
                acc_reg    <= '0;
            end
            ST_WALK_CMP: begin
                cur_reg <= mem_rdata;
                acc_reg <= mem_rdata.ch;   // held first entry
            end
            ST_PREV: begin
                prev_reg <= mem_rdata;
                negf_reg <= off_s[32] ^ gap_s[32];
                fm_reg   <= '0;
            end
            ST_DIV: begin
                if (div_done) fm_reg <= div_q;
            end
            ST_MUL_HI: phi_reg <= prod[49:0];
            ST_MUL_LO: plo_reg <= prod;
            ST_FIN:    acc_reg[ch_reg] <= lerp_val;
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (emit_go) begin
            out_status_reg <= status_reg;
            out_acc_reg    <= acc_reg;
            out_mark_reg   <= mark_reg;
            out_cx_reg     <= cx_reg;
            out_cy_reg     <= cy_reg;
            out_cz_reg     <= cz_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = out_status_reg;
    assign m_acc_lin_x = out_acc_reg[0];
    assign m_acc_lin_y = out_acc_reg[1];
    assign m_acc_lin_z = out_acc_reg[2];
    assign m_acc_ang_x = out_acc_reg[3];
    assign m_acc_ang_y = out_acc_reg[4];
    assign m_acc_ang_z = out_acc_reg[5];
    assign m_mark_out  = out_mark_reg;
    assign m_cog_out_x = out_cx_reg;
    assign m_cog_out_y = out_cy_reg;
    assign m_cog_out_z = out_cz_reg;

    // ---------------- checks ----------------
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count past table depth");

    a_walk_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> ({1'b0, cursor_reg} < count_reg))
        else $error("cursor outside filled table");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide phase");

    a_query_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (count_reg >= CNT_W'(2)))
        else $error("walk with fewer than two entries");

endmodule
`default_nettype wire
